// ----- rtl/core/flow_window_stability_detector_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the flow window stability detector
// Concurrent checks on rising clk, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef FLOW_WINDOW_STABILITY_DETECTOR_TOP_ASSERT_SVH
`define FLOW_WINDOW_STABILITY_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FWSD_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fwsd: same-cycle check failed");

// next-cycle implication
`define FWSD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fwsd: next-cycle check failed");

`else

`define FWSD_ASSERT_NOW(name, clk, rst, ante, cons)
`define FWSD_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/fwsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsd_pkg
// Widths, reset values and shared types of the flow window stability detector.
// ----------------------------------------------------------------------------
package fwsd_pkg;

  localparam int FLOW_W             = 17;
  localparam int TIME_W             = 32;
  localparam int CFG_W              = 16;
  localparam int COUNT_OUT_W        = 4;
  localparam int WINDOW_SAMPLES_DEF = 8;

  localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 16'd1000;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [FLOW_W-1:0] value;
  } cell_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } chain_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_FINISH,
    ST_EMIT
  } state_t;

endpackage

// ----- rtl/core/fwsd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsd channel interfaces
// Sample request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fwsd_sample_if;
  import fwsd_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [FLOW_W-1:0] flow;
  logic [TIME_W-1:0] time_ms;

  modport source (output valid, output mode, output flow, output time_ms, input ready);
  modport sink   (input valid, input mode, input flow, input time_ms, output ready);
endinterface

interface fwsd_result_if;
  import fwsd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   accepted;
  logic [COUNT_OUT_W-1:0] sample_count;
  logic [FLOW_W-1:0]      average_flow;
  logic [FLOW_W-1:0]      min_flow;
  logic [FLOW_W-1:0]      max_flow;
  logic                   stable;
  logic [FLOW_W-1:0]      suggested_flow;

  modport source (output valid, output accepted, output sample_count, output average_flow,
                  output min_flow, output max_flow, output stable, output suggested_flow,
                  input ready);
  modport sink   (input valid, input accepted, input sample_count, input average_flow,
                  input min_flow, input max_flow, input stable, input suggested_flow,
                  output ready);
endinterface

// ----- rtl/core/fwsd_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsd_cell
// One window slot: holds a sample and its valid bit, loads from its neighbor.
// ----------------------------------------------------------------------------
module fwsd_cell (
  input  logic               clk,
  input  logic               rst,
  input  fwsd_pkg::chain_ctl_t ctl,
  input  fwsd_pkg::cell_t    din,
  output fwsd_pkg::cell_t    dout
);
  import fwsd_pkg::*;

  logic              valid;
  logic [FLOW_W-1:0] value;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value <= din.value;
    end
  end

  assign dout.valid = valid;
  assign dout.value = value;

endmodule

// ----- rtl/core/fwsd_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsd_chain
// Row of window cells; each shift moves every sample one cell toward the tail.
// ----------------------------------------------------------------------------
module fwsd_chain #(
  parameter int WINDOW_SAMPLES = fwsd_pkg::WINDOW_SAMPLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fwsd_pkg::chain_ctl_t ctl,
  input  fwsd_pkg::cell_t      head,
  output fwsd_pkg::cell_t      tail
);
  import fwsd_pkg::*;

  cell_t link [WINDOW_SAMPLES+1];

  assign link[0] = head;

  for (genvar i = 0; i < WINDOW_SAMPLES; i++) begin : g_cell
    fwsd_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .din  (link[i]),
      .dout (link[i+1])
    );
  end

  assign tail = link[WINDOW_SAMPLES];

endmodule

// ----- rtl/core/fwsd_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsd_divider
// Restoring divider, one quotient bit per cycle, for the window mean.
// ----------------------------------------------------------------------------
module fwsd_divider #(
  parameter int SUM_W = 20,
  parameter int CNT_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);
  import fwsd_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  div;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W:0]    shifted;
  logic              fits;

  assign shifted = {rem, quo[SUM_W-1]};
  assign fits    = shifted >= {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      steps <= STEP_W'(SUM_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      div <= divisor;
      quo <= dividend;
    end else if (busy) begin
      // shift in the next dividend bit, subtract when it fits
      if (fits) begin
        rem <= CNT_W'(shifted - {1'b0, div});
      end else begin
        rem <= shifted[CNT_W-1:0];
      end
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ----- rtl/core/flow_window_stability_detector_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_window_stability_detector_top
// Windowed flow statistics with a sticky stability flag and suggested flow.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                         handshake
//  sample    in   mode, flow, time_ms                             valid/ready
//  result    out  accepted, sample_count, average/min/max_flow,   valid/ready
//                 stable, suggested_flow
//  cfg       in   cfg_data (min_interval_ms)                      cfg_we
//
//  An accepted sample is scanned by one full rotation of the cell chain, then
//  divided, one quotient bit per sum bit; clear and ignored requests skip both
//  steps and go straight to the result. One request is in work at a time; the
//  result register lets the next request in while a result waits. Reset is
//  synchronous and leaves the window empty with min_interval_ms at 1000; no
//  clearing pass is needed.
// ----------------------------------------------------------------------------
`include "flow_window_stability_detector_top_assert.svh"

module flow_window_stability_detector_top #(
  parameter int WINDOW_SAMPLES = fwsd_pkg::WINDOW_SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [fwsd_pkg::CFG_W-1:0] cfg_data,
  fwsd_sample_if.sink                sample,
  fwsd_result_if.source              result
);
  import fwsd_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_SAMPLES + 1);
  localparam int IDX_W = $clog2(WINDOW_SAMPLES);
  localparam int SUM_W = FLOW_W + $clog2(WINDOW_SAMPLES);
  localparam int TEN_W = FLOW_W + 4;

  state_t state, state_next;

  logic [CFG_W-1:0]  min_interval;
  logic              mode_q;
  logic [FLOW_W-1:0] flow_q;
  logic [TIME_W-1:0] time_q;
  logic [TIME_W-1:0] last_time;
  logic [CNT_W-1:0]  fill;
  logic              took;
  logic [FLOW_W-1:0] held_avg;
  logic [FLOW_W-1:0] held_min;
  logic [FLOW_W-1:0] held_max;
  logic              stable_flag;
  logic [FLOW_W-1:0] suggestion;
  logic [IDX_W-1:0]  scan_idx;
  logic [SUM_W-1:0]  sum_acc;
  logic [FLOW_W-1:0] min_acc;
  logic [FLOW_W-1:0] max_acc;

  logic              sample_ready;
  logic              res_valid;
  logic              emit_go;
  logic              take;
  logic              too_soon;
  logic [TIME_W-1:0] elapsed;
  chain_ctl_t        chain_ctl;
  cell_t             head;
  cell_t             tail;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  quotient;
  logic [FLOW_W-1:0] avg;
  logic [FLOW_W-1:0] spread;
  logic [TEN_W-1:0]  spread_x10;
  logic              steady;

  assign elapsed  = time_q - last_time;
  assign too_soon = (last_time != '0) && (elapsed < {{(TIME_W-CFG_W){1'b0}}, min_interval});
  assign take     = (mode_q == MODE_SAMPLE) && (flow_q != '0) && !too_soon;
  assign emit_go  = !res_valid || result.ready;

  assign avg        = quotient[FLOW_W-1:0];
  assign spread     = max_acc - min_acc;
  assign spread_x10 = ({4'b0, spread} << 3) + ({4'b0, spread} << 1);
  // spread <= floor(avg / 10) is the same as 10 * spread <= avg
  assign steady     = (fill == CNT_W'(WINDOW_SAMPLES)) && (avg != '0) &&
                      (spread_x10 <= {4'b0, avg});

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    sample_ready    = 1'b0;
    chain_ctl.shift = 1'b0;
    chain_ctl.clear = 1'b0;
    head.valid      = 1'b1;
    head.value      = flow_q;
    div_start       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample.valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (mode_q == MODE_CLEAR) begin
          chain_ctl.clear = 1'b1;
          state_next      = ST_EMIT;
        end else if (take) begin
          chain_ctl.shift = 1'b1;
          state_next      = ST_SCAN;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SCAN: begin
        // rotate the chain once around, tail feeds head
        chain_ctl.shift = 1'b1;
        head            = tail;
        if (scan_idx == IDX_W'(WINDOW_SAMPLES - 1)) begin
          state_next = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        div_start  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign sample.ready = sample_ready;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= MIN_INTERVAL_RST;
    end else if (cfg_we) begin
      min_interval <= cfg_data;
    end
  end

  // ---------------- request capture ----------------
  always_ff @(posedge clk) begin
    if (sample.valid && sample_ready) begin
      mode_q <= sample.mode;
      flow_q <= sample.flow;
      time_q <= sample.time_ms;
    end
  end

  // ---------------- window state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time   <= '0;
      fill        <= '0;
      took        <= 1'b0;
      held_avg    <= '0;
      held_min    <= '0;
      held_max    <= '0;
      stable_flag <= 1'b0;
      suggestion  <= '0;
    end else if (state == ST_CHECK) begin
      took <= 1'b0;
      if (mode_q == MODE_CLEAR) begin
        last_time   <= '0;
        fill        <= '0;
        held_avg    <= '0;
        held_min    <= '0;
        held_max    <= '0;
        stable_flag <= 1'b0;
        suggestion  <= '0;
      end else if (take) begin
        took      <= 1'b1;
        last_time <= time_q;
        if (fill != CNT_W'(WINDOW_SAMPLES)) begin
          fill <= fill + 1'b1;
        end
      end
    end else if (state == ST_FINISH) begin
      held_avg <= avg;
      held_min <= min_acc;
      held_max <= max_acc;
      if (steady) begin
        stable_flag <= 1'b1;
        suggestion  <= avg;
      end
    end
  end

  // ---------------- scan accumulators ----------------
  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      scan_idx <= '0;
      sum_acc  <= '0;
      min_acc  <= '1;
      max_acc  <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
      if (tail.valid) begin
        sum_acc <= sum_acc + SUM_W'(tail.value);
        if (tail.value < min_acc) begin
          min_acc <= tail.value;
        end
        if (tail.value > max_acc) begin
          max_acc <= tail.value;
        end
      end
    end
  end

  // ---------------- datapath units ----------------
  fwsd_chain #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctl  (chain_ctl),
    .head (head),
    .tail (tail)
  );

  fwsd_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_acc),
    .divisor  (fill),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_EMIT && emit_go) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && emit_go) begin
      result.accepted       <= took;
      result.sample_count   <= COUNT_OUT_W'(fill);
      result.average_flow   <= held_avg;
      result.min_flow       <= held_min;
      result.max_flow       <= held_max;
      result.stable         <= stable_flag;
      result.suggested_flow <= suggestion;
    end
  end

  assign result.valid = res_valid;

  // ---------------- assertions ----------------
  `FWSD_ASSERT_NEXT(a_accept_to_check, clk, rst, sample.valid && sample.ready, state == ST_CHECK)
  `FWSD_ASSERT_NOW(a_stable_drops_on_clear, clk, rst, $fell(stable_flag), $past(state == ST_CHECK && mode_q == MODE_CLEAR))
  `FWSD_ASSERT_NOW(a_held_range, clk, rst, state == ST_IDLE && fill != '0, held_min != '0 && held_min <= held_max)
  `FWSD_ASSERT_NOW(a_fill_bound, clk, rst, state == ST_IDLE, fill <= CNT_W'(WINDOW_SAMPLES))

endmodule
